// File: src/ect_pkg.sv
// Shared types and constants of the ear-clip triangulator.
package ect_pkg;

	localparam int IN_BITS  = 20;
	localparam int OUT_BITS = 6;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_AREA_RJ,
		ST_AREA_RI,
		ST_AREA_LD,
		ST_AREA_ST,
		ST_AREA_W,
		ST_FILL,
		ST_LOOP,
		ST_CAND_RA,
		ST_CAND_RB,
		ST_CAND_RC,
		ST_CAND_XA,
		ST_CAND_XB,
		ST_CAND_XC,
		ST_CAND_XD,
		ST_CAND_ST,
		ST_CAND_W,
		ST_SCAN_CHK,
		ST_SCAN_RI,
		ST_SCAN_RX,
		ST_SCAN_LD,
		ST_D1_ST,
		ST_D1_W,
		ST_D2_ST,
		ST_D2_W,
		ST_D3_ST,
		ST_D3_W,
		ST_ADV,
		ST_EMIT_EAR,
		ST_SHIFT_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FIN_R0,
		ST_FIN_R1,
		ST_FIN_R2,
		ST_FIN_LD,
		ST_EMIT_FIN,
		ST_EMIT_END
	} state_t;

	typedef enum logic [2:0] {
		SEL_AREA,
		SEL_CAND,
		SEL_D1,
		SEL_D2,
		SEL_D3
	} cross_sel_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MUL1,
		PH_MUL2
	} cross_phase_t;

	typedef struct packed {
		logic done;
		logic pos;
		logic neg;
	} cross_stat_t;

endpackage

// File: src/ect_cross.sv
// Shared cross-product unit: cross(p1 - p0, p2 - p0) over one multiplier in two passes.
module ect_cross #(
	parameter int W = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [W-1:0]     p0x,
	input  logic signed [W-1:0]     p0y,
	input  logic signed [W-1:0]     p1x,
	input  logic signed [W-1:0]     p1y,
	input  logic signed [W-1:0]     p2x,
	input  logic signed [W-1:0]     p2y,
	output ect_pkg::cross_stat_t    stat,
	output logic signed [2*W+2:0]   res
);
	import ect_pkg::*;

	cross_phase_t             phase_q;
	logic                     done_q;
	logic signed [W:0]        ux_q, uy_q, vx_q, vy_q;
	logic signed [W:0]        ma, mb;
	logic signed [2*W+1:0]    prod;
	logic signed [2*W+1:0]    prod_q;
	logic signed [2*W+2:0]    res_q;

	// first pass ux*vy, second pass uy*vx
	assign ma   = (phase_q == PH_MUL2) ? uy_q : ux_q;
	assign mb   = (phase_q == PH_MUL2) ? vx_q : vy_q;
	assign prod = ma * mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: if (start) phase_q <= PH_MUL1;
				PH_MUL1: phase_q <= PH_MUL2;
				PH_MUL2: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && phase_q == PH_IDLE) begin
			ux_q <= {p1x[W-1], p1x} - {p0x[W-1], p0x};
			uy_q <= {p1y[W-1], p1y} - {p0y[W-1], p0y};
			vx_q <= {p2x[W-1], p2x} - {p0x[W-1], p0x};
			vy_q <= {p2y[W-1], p2y} - {p0y[W-1], p0y};
		end
		if (phase_q == PH_MUL1)
			prod_q <= prod;
		if (phase_q == PH_MUL2)
			res_q <= {prod_q[2*W+1], prod_q} - {prod[2*W+1], prod};
	end

	assign res       = res_q;
	assign stat.done = done_q;
	assign stat.pos  = !res_q[2*W+2] && (res_q != '0);
	assign stat.neg  = res_q[2*W+2];

endmodule

// File: src/ear_clip_triangulator_core.sv
// Top level of the ear-clip triangulator: vertex store, sequencer and result register.
//
// Usage. Vertices enter on the input channel (vertex_x, vertex_y, is_last) with
// in_valid / in_stall; one item per cycle is taken while the block is idle and
// written to the vertex store while it has room. The item with is_last set closes the polygon:
// in_stall rises and the block triangulates on its own until the end item of
// the run has been loaded into the result register.
// Results leave on the output channel (tri_a, tri_b, tri_c and flags) with
// out_valid / out_stall. Each ear is one item; the item with end_of_run closes
// the run. A stalled receiver holds the result register and the sequencer
// waits in its emit state; nothing is dropped.
// Sequence. After the last vertex the block sums the winding over the vertices,
// builds the index list and then tests ear candidates; a convex candidate is
// followed by a scan of the remaining vertices for containment (its own corners
// are skipped), and when an ear is removed the index entries after it are
// shifted down. The pace is set by the single cross-product unit (two multiplier
// passes per test) and the single read port of each store.
// Reset clears the control state, vertex count and overflow flag; stores are
// not cleared, only entries written for the current polygon are read.
module ear_clip_triangulator_core #(
	parameter int MAX_VERTS  = 64,
	parameter int COORD_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [ect_pkg::IN_BITS-1:0]  vertex_x,
	input  logic signed [ect_pkg::IN_BITS-1:0]  vertex_y,
	input  logic                                is_last,
	input  logic                                in_valid,
	output logic                                in_stall,
	output logic [ect_pkg::OUT_BITS-1:0]        tri_a,
	output logic [ect_pkg::OUT_BITS-1:0]        tri_b,
	output logic [ect_pkg::OUT_BITS-1:0]        tri_c,
	output logic                                tri_valid,
	output logic                                gave_up,
	output logic                                overflowed,
	output logic                                end_of_run,
	output logic                                out_valid,
	input  logic                                out_stall
);
	import ect_pkg::*;

	localparam int W      = (COORD_BITS < IN_BITS) ? COORD_BITS : IN_BITS;
	localparam int IDX_W  = $clog2(MAX_VERTS);
	localparam int CNT_W  = $clog2(MAX_VERTS + 1);
	localparam int GW     = 2 * CNT_W;
	localparam int RW     = 2 * W + 3;
	localparam int AW     = RW + CNT_W;

	function automatic logic [OUT_BITS-1:0] idx_out(input logic [IDX_W-1:0] v);
		logic [IDX_W+OUT_BITS-1:0] e;
		e = {{OUT_BITS{1'b0}}, v};
		return e[OUT_BITS-1:0];
	endfunction

	state_t state_q, state_nx;

	// vertex store and index list
	logic signed [W-1:0] x_mem [MAX_VERTS];
	logic signed [W-1:0] y_mem [MAX_VERTS];
	logic [IDX_W-1:0]    idx_mem [MAX_VERTS];
	logic signed [W-1:0] xrd_q, yrd_q;
	logic [IDX_W-1:0]    ird_q;

	logic                cwe;
	logic [IDX_W-1:0]    craddr;
	logic                iwe;
	logic [IDX_W-1:0]    iwaddr, iwdata, iraddr;

	// control and loop registers
	logic [CNT_W-1:0]    cnt_q, cnt_nx, n_q, q_q;
	logic                ovf_q, ovf_run_q;
	logic                room, in_acc;
	logic [GW-1:0]       guard_q;
	logic [IDX_W-1:0]    i_q, j_q, f_q, ia_q, ib_q, ic_q;
	logic [IDX_W-1:0]    va_q, vb_q, vc_q;
	logic signed [AW-1:0] acc_q;
	logic                area_pos;
	logic                pos1_q, neg1_q, pos2_q, neg2_q;
	logic                in_tri;
	logic                skip;
	logic [CNT_W-1:0]    ic_inc, q_p1;
	logic [IDX_W-1:0]    ic_wrap;
	logic [CNT_W-1:0]    fill_down;

	// operand registers
	logic signed [W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, px_q, py_q;

	// cross-product unit
	logic                cst_start;
	cross_sel_t          sel;
	logic signed [W-1:0] p0x, p0y, p1x, p1y, p2x, p2y;
	cross_stat_t         cst;
	logic signed [RW-1:0] cres;

	// result register
	logic                out_valid_q, out_ld, out_free;
	logic [OUT_BITS-1:0] ta_q, tb_q, tc_q;
	logic                tv_q, gv_q, ov_q, eor_q;

	assign room     = cnt_q < CNT_W'(MAX_VERTS);
	assign in_acc   = in_valid && !in_stall;
	assign cnt_nx   = room ? cnt_q + 1'b1 : cnt_q;
	assign cwe      = in_acc && room;
	assign out_free = !out_valid_q || !out_stall;
	assign area_pos = !acc_q[AW-1] && (acc_q != '0);
	assign in_tri   = (pos1_q && pos2_q && cst.pos) || (neg1_q && neg2_q && cst.neg);
	assign skip     = (q_q == CNT_W'(ia_q)) || (q_q == CNT_W'(ib_q)) || (q_q == CNT_W'(ic_q));
	assign ic_inc   = CNT_W'(ic_q) + 1'b1;
	assign ic_wrap  = (ic_inc == n_q) ? '0 : ic_inc[IDX_W-1:0];
	assign q_p1     = q_q + 1'b1;
	assign fill_down = n_q - 1'b1 - CNT_W'(f_q);

	// stores: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cwe) begin
			x_mem[cnt_q[IDX_W-1:0]] <= vertex_x[W-1:0];
			y_mem[cnt_q[IDX_W-1:0]] <= vertex_y[W-1:0];
		end
		xrd_q <= x_mem[craddr];
		yrd_q <= y_mem[craddr];
	end

	always_ff @(posedge clk) begin
		if (iwe)
			idx_mem[iwaddr] <= iwdata;
		ird_q <= idx_mem[iraddr];
	end

	// operand select for the shared unit
	always_comb begin
		p0x = ax_q; p0y = ay_q; p1x = bx_q; p1y = by_q; p2x = cx_q; p2y = cy_q;
		unique case (sel)
			SEL_AREA: begin
				p0x = '0;   p0y = '0;   p1x = px_q; p1y = py_q; p2x = ax_q; p2y = ay_q;
			end
			SEL_CAND: begin
				p0x = ax_q; p0y = ay_q; p1x = bx_q; p1y = by_q; p2x = cx_q; p2y = cy_q;
			end
			SEL_D1: begin
				p0x = bx_q; p0y = by_q; p1x = px_q; p1y = py_q; p2x = ax_q; p2y = ay_q;
			end
			SEL_D2: begin
				p0x = cx_q; p0y = cy_q; p1x = px_q; p1y = py_q; p2x = bx_q; p2y = by_q;
			end
			SEL_D3: begin
				p0x = ax_q; p0y = ay_q; p1x = px_q; p1y = py_q; p2x = cx_q; p2y = cy_q;
			end
			default: ;
		endcase
	end

	ect_cross #(.W(W)) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cst_start),
		.p0x    (p0x),
		.p0y    (p0y),
		.p1x    (p1x),
		.p1y    (p1y),
		.p2x    (p2x),
		.p2y    (p2y),
		.stat   (cst),
		.res    (cres)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && is_last)
				state_nx = (cnt_nx < CNT_W'(3)) ? ST_EMIT_END : ST_AREA_RJ;
			ST_AREA_RJ: state_nx = ST_AREA_RI;
			ST_AREA_RI: state_nx = ST_AREA_LD;
			ST_AREA_LD: state_nx = ST_AREA_ST;
			ST_AREA_ST: state_nx = ST_AREA_W;
			ST_AREA_W: if (cst.done)
				state_nx = (CNT_W'(i_q) == n_q - 1'b1) ? ST_FILL : ST_AREA_RJ;
			ST_FILL: if (CNT_W'(f_q) == n_q - 1'b1) state_nx = ST_LOOP;
			ST_LOOP: begin
				priority if (n_q > CNT_W'(3) && guard_q != '0) state_nx = ST_CAND_RA;
				else if (n_q == CNT_W'(3))                   state_nx = ST_FIN_R0;
				else                                         state_nx = ST_EMIT_END;
			end
			ST_CAND_RA: state_nx = ST_CAND_RB;
			ST_CAND_RB: state_nx = ST_CAND_RC;
			ST_CAND_RC: state_nx = ST_CAND_XA;
			ST_CAND_XA: state_nx = ST_CAND_XB;
			ST_CAND_XB: state_nx = ST_CAND_XC;
			ST_CAND_XC: state_nx = ST_CAND_XD;
			ST_CAND_XD: state_nx = ST_CAND_ST;
			ST_CAND_ST: state_nx = ST_CAND_W;
			ST_CAND_W: if (cst.done) state_nx = cst.pos ? ST_SCAN_CHK : ST_ADV;
			ST_SCAN_CHK: begin
				priority if (q_q == n_q) state_nx = ST_EMIT_EAR;
				else if (!skip)          state_nx = ST_SCAN_RI;
				else                     state_nx = ST_SCAN_CHK;
			end
			ST_SCAN_RI: state_nx = ST_SCAN_RX;
			ST_SCAN_RX: state_nx = ST_SCAN_LD;
			ST_SCAN_LD: state_nx = ST_D1_ST;
			ST_D1_ST:   state_nx = ST_D1_W;
			ST_D1_W: if (cst.done) state_nx = ST_D2_ST;
			ST_D2_ST:   state_nx = ST_D2_W;
			ST_D2_W: if (cst.done) state_nx = ST_D3_ST;
			ST_D3_ST:   state_nx = ST_D3_W;
			ST_D3_W: if (cst.done) state_nx = in_tri ? ST_ADV : ST_SCAN_CHK;
			ST_ADV:     state_nx = ST_LOOP;
			ST_EMIT_EAR: if (out_free) state_nx = ST_SHIFT_CHK;
			ST_SHIFT_CHK: state_nx = (q_p1 >= n_q) ? ST_LOOP : ST_SHIFT_RD;
			ST_SHIFT_RD: state_nx = ST_SHIFT_WR;
			ST_SHIFT_WR: state_nx = ST_SHIFT_CHK;
			ST_FIN_R0:  state_nx = ST_FIN_R1;
			ST_FIN_R1:  state_nx = ST_FIN_R2;
			ST_FIN_R2:  state_nx = ST_FIN_LD;
			ST_FIN_LD:  state_nx = ST_EMIT_FIN;
			ST_EMIT_FIN: if (out_free) state_nx = ST_IDLE;
			ST_EMIT_END: if (out_free) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// control outputs: handshake, memory ports, unit start
	always_comb begin
		in_stall  = 1'b1;
		iwe       = 1'b0;
		iwaddr    = f_q;
		iwdata    = area_pos ? f_q : fill_down[IDX_W-1:0];
		iraddr    = ia_q;
		craddr    = j_q;
		cst_start = 1'b0;
		sel       = SEL_CAND;
		out_ld    = 1'b0;
		unique case (state_q)
			ST_IDLE:    in_stall = 1'b0;
			ST_AREA_RJ: craddr = j_q;
			ST_AREA_RI: craddr = i_q;
			ST_AREA_ST: begin
				cst_start = 1'b1;
				sel       = SEL_AREA;
			end
			ST_AREA_W:  sel = SEL_AREA;
			ST_FILL:    iwe = 1'b1;
			ST_CAND_RA: iraddr = ia_q;
			ST_CAND_RB: iraddr = ib_q;
			ST_CAND_RC: iraddr = ic_q;
			ST_CAND_XA: craddr = va_q;
			ST_CAND_XB: craddr = vb_q;
			ST_CAND_XC: craddr = vc_q;
			ST_CAND_ST: cst_start = 1'b1;
			ST_SCAN_RI: iraddr = q_q[IDX_W-1:0];
			ST_SCAN_RX: craddr = ird_q;
			ST_D1_ST: begin
				cst_start = 1'b1;
				sel       = SEL_D1;
			end
			ST_D2_ST: begin
				cst_start = 1'b1;
				sel       = SEL_D2;
			end
			ST_D3_ST: begin
				cst_start = 1'b1;
				sel       = SEL_D3;
			end
			ST_SHIFT_RD: iraddr = q_p1[IDX_W-1:0];
			ST_SHIFT_WR: begin
				iwe    = 1'b1;
				iwaddr = q_q[IDX_W-1:0];
				iwdata = ird_q;
			end
			ST_FIN_R0:   iraddr = '0;
			ST_FIN_R1:   iraddr = IDX_W'(1);
			ST_FIN_R2:   iraddr = IDX_W'(2);
			ST_EMIT_EAR: out_ld = out_free;
			ST_EMIT_FIN: out_ld = out_free;
			ST_EMIT_END: out_ld = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_acc) begin
				if (is_last) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					cnt_q <= cnt_nx;
					ovf_q <= ovf_q | !room;
				end
			end
		end
	end

	// loop and operand registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_acc && is_last) begin
				n_q       <= cnt_nx;
				ovf_run_q <= ovf_q | !room;
				guard_q   <= GW'(cnt_nx) * GW'(cnt_nx);
				i_q       <= '0;
				j_q       <= cnt_nx[IDX_W-1:0] - 1'b1;
				acc_q     <= '0;
				ia_q      <= '0;
				ib_q      <= IDX_W'(1);
				ic_q      <= IDX_W'(2);
			end
			ST_AREA_RI: begin
				px_q <= xrd_q;
				py_q <= yrd_q;
			end
			ST_AREA_LD: begin
				ax_q <= xrd_q;
				ay_q <= yrd_q;
			end
			ST_AREA_W: if (cst.done) begin
				acc_q <= acc_q + AW'(cres);
				j_q   <= i_q;
				i_q   <= i_q + 1'b1;
				f_q   <= '0;
			end
			ST_FILL: f_q <= f_q + 1'b1;
			ST_LOOP: if (n_q > CNT_W'(3) && guard_q != '0)
				guard_q <= guard_q - 1'b1;
			ST_CAND_RB: va_q <= ird_q;
			ST_CAND_RC: vb_q <= ird_q;
			ST_CAND_XA: vc_q <= ird_q;
			ST_CAND_XB: begin
				ax_q <= xrd_q;
				ay_q <= yrd_q;
			end
			ST_CAND_XC: begin
				bx_q <= xrd_q;
				by_q <= yrd_q;
			end
			ST_CAND_XD: begin
				cx_q <= xrd_q;
				cy_q <= yrd_q;
			end
			ST_CAND_W: q_q <= '0;
			ST_SCAN_CHK: if (q_q != n_q && skip) q_q <= q_p1;
			ST_SCAN_LD: begin
				px_q <= xrd_q;
				py_q <= yrd_q;
			end
			ST_D1_W: if (cst.done) begin
				pos1_q <= cst.pos;
				neg1_q <= cst.neg;
			end
			ST_D2_W: if (cst.done) begin
				pos2_q <= cst.pos;
				neg2_q <= cst.neg;
			end
			ST_D3_W: if (cst.done && !in_tri) q_q <= q_p1;
			ST_ADV: begin
				ia_q <= ib_q;
				ib_q <= ic_q;
				ic_q <= ic_wrap;
			end
			ST_EMIT_EAR: q_q <= CNT_W'(ib_q);
			ST_SHIFT_CHK: if (q_p1 >= n_q) begin
				n_q  <= n_q - 1'b1;
				ia_q <= '0;
				ib_q <= IDX_W'(1);
				ic_q <= IDX_W'(2);
			end
			ST_SHIFT_WR: q_q <= q_p1;
			ST_FIN_R1: va_q <= ird_q;
			ST_FIN_R2: vb_q <= ird_q;
			ST_FIN_LD: vc_q <= ird_q;
			default: ;
		endcase
	end

	// result register: hold while stalled, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_ld)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (state_q == ST_EMIT_END) begin
				ta_q  <= '0;
				tb_q  <= '0;
				tc_q  <= '0;
				tv_q  <= 1'b0;
				gv_q  <= n_q > CNT_W'(3);
				ov_q  <= ovf_run_q;
				eor_q <= 1'b1;
			end else begin
				// triangle leaves as a, c, b
				ta_q  <= idx_out(va_q);
				tb_q  <= idx_out(vc_q);
				tc_q  <= idx_out(vb_q);
				tv_q  <= 1'b1;
				gv_q  <= 1'b0;
				ov_q  <= (state_q == ST_EMIT_FIN) ? ovf_run_q : 1'b0;
				eor_q <= state_q == ST_EMIT_FIN;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign tri_a      = ta_q;
	assign tri_b      = tb_q;
	assign tri_c      = tc_q;
	assign tri_valid  = tv_q;
	assign gave_up    = gv_q;
	assign overflowed = ov_q;
	assign end_of_run = eor_q;

	a_cand_more_than_three: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAND_RA) |-> (n_q > CNT_W'(3)))
		else $error("ear candidate started with three or fewer indices");

	a_cand_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAND_RA) |->
		(CNT_W'(ia_q) < n_q && CNT_W'(ib_q) < n_q && CNT_W'(ic_q) < n_q))
		else $error("candidate index beyond remaining list");

	a_mid_item_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !end_of_run) |-> (tri_valid && !gave_up && !overflowed))
		else $error("flags set on an item before the end of the run");

	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		cst_start |=> !cst_start)
		else $error("cross unit started on consecutive cycles");

endmodule
